[design/sli_pkg.sv]
package sli_pkg;

	// default sizes
	localparam int DEF_MAX_LISTS   = 8;
	localparam int DEF_LIST_DEPTH  = 1024;
	localparam int DEF_DOC_ID_BITS = 16;

	// most results of one run
	localparam int RESULT_CAP = 64;

	// command codes
	localparam logic [2:0] CMD_APPEND = 3'd0;
	localparam logic [2:0] CMD_MARK   = 3'd1;
	localparam logic [2:0] CMD_UNMARK = 3'd2;
	localparam logic [2:0] CMD_CLEAR  = 3'd3;
	localparam logic [2:0] CMD_RUN    = 3'd4;

	// configuration register indexes
	localparam logic CFG_LIST_COUNT = 1'b0;
	localparam logic CFG_COPY_LIMIT = 1'b1;

	// controller to datapath
	typedef struct packed {
		logic clr_step;
		logic exec;
		logic init;
		logic pstart;
		logic cmp;
		logic del;
		logic pend;
		logic ochk;
		logic oemit;
		logic out_phase;
	} ctl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clr_last;
		logic merge_done;
		logic lt;
		logic gt;
		logic next_pass;
		logic out_none;
		logic out_last;
	} dp_sts_t;

endpackage

[design/sli_ctrl.sv]
module sli_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [2:0]        cmd,
	input  sli_pkg::dp_sts_t  sts,
	output sli_pkg::ctl_cmd_t ctl,
	output logic              busy
);
	import sli_pkg::*;

	typedef enum logic [10:0] {
		S_CLEAR  = 11'b000_0000_0001,
		S_IDLE   = 11'b000_0000_0010,
		S_INIT   = 11'b000_0000_0100,
		S_PSTART = 11'b000_0000_1000,
		S_RD     = 11'b000_0001_0000,
		S_CMP    = 11'b000_0010_0000,
		S_DEL    = 11'b000_0100_0000,
		S_PEND   = 11'b000_1000_0000,
		S_OCHK   = 11'b001_0000_0000,
		S_ORD    = 11'b010_0000_0000,
		S_OEM    = 11'b100_0000_0000
	} state_t;

	state_t state_q, state_d;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR:  if (sts.clr_last) state_d = S_IDLE;
			S_IDLE:   if (start && cmd == CMD_RUN) state_d = S_INIT;
			S_INIT:   state_d = S_PSTART;
			S_PSTART: state_d = S_RD;
			S_RD:     state_d = sts.merge_done ? S_PEND : S_CMP;
			S_CMP:    state_d = (sts.lt || sts.gt) ? S_RD : S_DEL;
			S_DEL:    state_d = S_RD;
			S_PEND:   state_d = sts.next_pass ? S_PSTART : S_OCHK;
			S_OCHK:   state_d = sts.out_none ? S_IDLE : S_ORD;
			S_ORD:    state_d = S_OEM;
			S_OEM:    state_d = sts.out_last ? S_IDLE : S_ORD;
			default:  state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// commands to the datapath
	always_comb begin
		ctl.clr_step  = (state_q == S_CLEAR);
		ctl.exec      = (state_q == S_IDLE) && start;
		ctl.init      = (state_q == S_INIT);
		ctl.pstart    = (state_q == S_PSTART);
		ctl.cmp       = (state_q == S_CMP);
		ctl.del       = (state_q == S_DEL);
		ctl.pend      = (state_q == S_PEND);
		ctl.ochk      = (state_q == S_OCHK);
		ctl.oemit     = (state_q == S_OEM);
		ctl.out_phase = (state_q == S_OCHK) || (state_q == S_ORD) || (state_q == S_OEM);
	end

	assign busy = (state_q != S_IDLE);

endmodule

[design/sli_dp.sv]
module sli_dp #(
	parameter int MAX_LISTS   = sli_pkg::DEF_MAX_LISTS,
	parameter int LIST_DEPTH  = sli_pkg::DEF_LIST_DEPTH,
	parameter int DOC_ID_BITS = sli_pkg::DEF_DOC_ID_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  sli_pkg::ctl_cmd_t ctl,
	output sli_pkg::dp_sts_t  sts,
	input  logic [2:0]        cmd,
	input  logic [2:0]        list_index,
	input  logic [15:0]       doc_id,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [6:0]        cfg_data,
	output logic              res_valid,
	output logic [15:0]       doc_id_res,
	output logic [10:0]       total_matches,
	output logic              last,
	output logic              empty_res
);
	import sli_pkg::*;

	localparam int DW   = DOC_ID_BITS;
	localparam int AW   = $clog2(LIST_DEPTH);
	localparam int LW   = (MAX_LISTS > 2) ? $clog2(MAX_LISTS) : 1;
	localparam int PW   = $clog2(MAX_LISTS + 1);
	localparam int LENW = $clog2(LIST_DEPTH + 1);

	// configuration
	logic [3:0] list_count_q;
	logic [6:0] copy_limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			list_count_q <= 4'd2;
			copy_limit_q <= 7'd64;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_LIST_COUNT: list_count_q <= cfg_data[3:0];
				CFG_COPY_LIMIT: copy_limit_q <= cfg_data;
				default:        copy_limit_q <= copy_limit_q;
			endcase
		end
	end

	// storage
	logic [DW-1:0] lst_mem [MAX_LISTS * (2 ** AW)];
	logic [DW-1:0] wk_mem  [2 * (2 ** AW)];
	logic          mark_mem [2 ** DW];
	logic [LENW-1:0] len_q [MAX_LISTS];

	// merge and output registers
	logic [LENW-1:0] alen_q, blen_q, ia_q, jb_q, n_q;
	logic [PW-1:0]   p_q;
	logic [DW-1:0]   rda_q, rdb_q, rdw_q;
	logic            del_q;
	logic [DW-1:0]   clr_q;
	logic [6:0]      oidx_q, k_q;

	logic [LW-1:0]   li_idx, lensel;
	logic [LENW-1:0] len_sel;
	logic [DW-1:0]   id_in, a_val;
	logic            app_ok, next_pass;
	logic [PW-1:0]   nlists;
	logic [6:0]      limit;
	logic [AW:0]     wk_raddr;

	assign li_idx  = LW'(list_index);
	assign lensel  = ctl.init ? '0 : (ctl.pstart ? p_q[LW-1:0] : li_idx);
	assign len_sel = len_q[lensel];
	assign id_in   = DW'(doc_id);
	assign app_ok  = (int'(list_index) < MAX_LISTS) && (int'(len_sel) < LIST_DEPTH);
	assign a_val   = (p_q == PW'(1)) ? rda_q : rdw_q;

	// list count clamped to the supported range
	always_comb begin
		if (list_count_q < 4'd2) begin
			nlists = PW'(2);
		end else if (int'(list_count_q) > MAX_LISTS) begin
			nlists = PW'(MAX_LISTS);
		end else begin
			nlists = PW'(list_count_q);
		end
	end

	assign limit     = (int'(copy_limit_q) > RESULT_CAP) ? 7'(RESULT_CAP) : copy_limit_q;
	assign next_pass = (n_q != '0) && ((int'(p_q) + 1) < int'(nlists));
	assign wk_raddr  = ctl.out_phase ? {p_q[0], AW'(oidx_q)} : {~p_q[0], ia_q[AW-1:0]};

	// status
	always_comb begin
		sts.clr_last   = &clr_q;
		sts.merge_done = (ia_q >= alen_q) || (jb_q >= blen_q);
		sts.lt         = a_val < rdb_q;
		sts.gt         = a_val > rdb_q;
		sts.next_pass  = next_pass;
		sts.out_none   = (alen_q == '0) || (limit == 7'd0);
		sts.out_last   = (int'(oidx_q) + 1) == int'(k_q);
	end

	// list lengths
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_LISTS; i++) begin
				len_q[i] <= '0;
			end
		end else if (ctl.exec && cmd == CMD_APPEND && app_ok) begin
			len_q[li_idx] <= len_sel + LENW'(1);
		end else if (ctl.exec && cmd == CMD_CLEAR) begin
			for (int i = 0; i < MAX_LISTS; i++) begin
				len_q[i] <= '0;
			end
		end
	end

	// list store, two registered read ports
	always_ff @(posedge clk) begin
		if (ctl.exec && cmd == CMD_APPEND && app_ok) begin
			lst_mem[{li_idx, len_sel[AW-1:0]}] <= id_in;
		end
		rda_q <= lst_mem[{LW'(0), ia_q[AW-1:0]}];
		rdb_q <= lst_mem[{p_q[LW-1:0], jb_q[AW-1:0]}];
	end

	// work buffers
	always_ff @(posedge clk) begin
		if (ctl.del && !del_q && int'(n_q) < LIST_DEPTH) begin
			wk_mem[{p_q[0], n_q[AW-1:0]}] <= a_val;
		end
		rdw_q <= wk_mem[wk_raddr];
	end

	// deletion marks, cleared after reset
	always_ff @(posedge clk) begin
		if (ctl.clr_step) begin
			mark_mem[clr_q] <= 1'b0;
		end else if (ctl.exec && (cmd == CMD_MARK || cmd == CMD_UNMARK)) begin
			mark_mem[id_in] <= (cmd == CMD_MARK);
		end
		del_q <= mark_mem[a_val];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (ctl.clr_step) begin
			clr_q <= clr_q + DW'(1);
		end
	end

	// merge pointers
	always_ff @(posedge clk) begin
		if (ctl.init) begin
			alen_q <= len_sel;
			p_q    <= PW'(1);
		end
		if (ctl.pstart) begin
			blen_q <= len_sel;
			ia_q   <= '0;
			jb_q   <= '0;
			n_q    <= '0;
		end
		if (ctl.cmp) begin
			if (sts.lt) begin
				ia_q <= ia_q + LENW'(1);
			end else if (sts.gt) begin
				jb_q <= jb_q + LENW'(1);
			end
		end
		if (ctl.del) begin
			ia_q <= ia_q + LENW'(1);
			jb_q <= jb_q + LENW'(1);
			if (!del_q && int'(n_q) < LIST_DEPTH) begin
				n_q <= n_q + LENW'(1);
			end
		end
		if (ctl.pend) begin
			alen_q <= n_q;
			if (next_pass) begin
				p_q <= p_q + PW'(1);
			end
		end
		if (ctl.ochk) begin
			k_q    <= (int'(alen_q) < int'(limit)) ? 7'(alen_q) : limit;
			oidx_q <= 7'd0;
		end
		if (ctl.oemit) begin
			oidx_q <= oidx_q + 7'd1;
		end
	end

	// result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else begin
			res_valid <= (ctl.ochk && sts.out_none) || ctl.oemit;
		end
	end

	always_ff @(posedge clk) begin
		doc_id_res    <= ctl.ochk ? 16'd0 : 16'(rdw_q);
		total_matches <= 11'(alen_q);
		last          <= ctl.ochk ? 1'b1 : sts.out_last;
		empty_res     <= ctl.ochk;
	end

	// checks
	a_del_count: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.del |-> n_q <= ia_q)
		else $error("merge output count ran past source pointer");
	a_out_idx: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.oemit |-> oidx_q < k_q)
		else $error("output index beyond copy count");
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && empty_res |-> last)
		else $error("empty beat not marked last");

endmodule

[design/sorted_list_intersect.sv]
// channel   signals                                   direction  handshake
// command   start, cmd, list_index, doc_id            in         start && !busy
// config    cfg_we, cfg_index, cfg_data               in         cfg_we, no wait
// result    res_valid, doc_id_res, total_matches,     out        res_valid, one cycle
//           last, empty_res
// after reset a clearing pass over all deletion marks holds busy until it is done
// append, mark, unmark and clear are done while idle, busy stays low
// a run sets up, then each pass reads and compares, steps the smaller side or, on an equal
// pair, checks its mark and steps both; then come an output check and a read and emit per beat
// results cannot be stalled: each beat is valid for exactly one cycle
module sorted_list_intersect #(
	parameter int MAX_LISTS   = sli_pkg::DEF_MAX_LISTS,
	parameter int LIST_DEPTH  = sli_pkg::DEF_LIST_DEPTH,
	parameter int DOC_ID_BITS = sli_pkg::DEF_DOC_ID_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  cmd,
	input  logic [2:0]  list_index,
	input  logic [15:0] doc_id,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [6:0]  cfg_data,
	output logic        res_valid,
	output logic [15:0] doc_id_res,
	output logic [10:0] total_matches,
	output logic        last,
	output logic        empty_res
);
	import sli_pkg::*;

	ctl_cmd_t ctl;
	dp_sts_t  sts;

	// controller
	sli_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.sts    (sts),
		.ctl    (ctl),
		.busy   (busy)
	);

	// datapath
	sli_dp #(
		.MAX_LISTS   (MAX_LISTS),
		.LIST_DEPTH  (LIST_DEPTH),
		.DOC_ID_BITS (DOC_ID_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.sts           (sts),
		.cmd           (cmd),
		.list_index    (list_index),
		.doc_id        (doc_id),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.res_valid     (res_valid),
		.doc_id_res    (doc_id_res),
		.total_matches (total_matches),
		.last          (last),
		.empty_res     (empty_res)
	);

endmodule
